FILE: src/bamu_pkg.sv
// Package for the decimal add / multiply unit.
// Shared constants, controller state type and controller/datapath interface structs.
// No dependencies.
package bamu_pkg;

    localparam int IO_DIGITS      = 30;
    localparam int HALF_DIGITS    = 15;
    localparam int HALF_W         = 4 * HALF_DIGITS;
    localparam int IO_W           = 4 * IO_DIGITS;
    localparam int DIGITS_DEFAULT = 30;

    // column sum: at most 30 products of 81 -> 2430, fits 12 bits
    localparam int ACC_W          = 12;
    // carry out of a column sum stays below 512
    localparam int CARRY_W        = 9;
    // floor(v / 10) == (v * 3277) >> 15 for every v below 4096
    localparam int RECIP          = 3277;
    localparam int RECIP_SHIFT    = 15;
    localparam int RECIP_PROD_W   = 2 * ACC_W;

    localparam logic [3:0] MAX_DIGIT = 4'd9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } bamu_state_t;

    typedef struct packed {
        logic load;
        logic acc_en;
        logic norm_en;
        logic out_load;
    } bamu_cmd_t;

    typedef struct packed {
        logic bad;
    } bamu_status_t;

endpackage

FILE: src/bcd_add_multiply_unit_top.sv
// Top level of the decimal add / multiply unit (packed BCD, up to 30 digits).
// Instantiates bamu_ctrl and bamu_dpath; depends on bamu_pkg.
//
//   channel | prefix | direction | beat contents
//   --------+--------+-----------+---------------------------------------------
//   input   | s_     | in        | operation, a_high, a_low, b_high, b_low
//   result  | m_     | out       | result_high, result_low, overflow, bad_digit
//
// One beat at a time: an accepted beat passes through the accept cycle, W multiplier-digit
// steps (W = min(DIGITS, 30)), one trailing normalizer step and the finish cycle;
// m_valid is registered from the result load in the finish cycle.
// A beat with a bad digit leaves the digit loop at its first step and goes to the finish cycle.
// The result sits in an output register; a new beat is taken while it waits.
// A stalled result holds the unit in its finish state until m_ready.
// Reset (aresetn low at a clock edge) empties the unit and drops m_valid.
module bcd_add_multiply_unit_top #(
    parameter int DIGITS = bamu_pkg::DIGITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [bamu_pkg::HALF_W-1:0] s_a_high,
    input  logic [bamu_pkg::HALF_W-1:0] s_a_low,
    input  logic [bamu_pkg::HALF_W-1:0] s_b_high,
    input  logic [bamu_pkg::HALF_W-1:0] s_b_low,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bamu_pkg::HALF_W-1:0] m_result_high,
    output logic [bamu_pkg::HALF_W-1:0] m_result_low,
    output logic                        m_overflow,
    output logic                        m_bad_digit
);
    import bamu_pkg::*;

    bamu_cmd_t    cmd;
    bamu_status_t status;

    bamu_ctrl #(
        .DIGITS (DIGITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bamu_dpath #(
        .DIGITS (DIGITS)
    ) u_dpath (
        .aclk        (aclk),
        .cmd         (cmd),
        .status      (status),
        .operation   (s_operation),
        .a_high      (s_a_high),
        .a_low       (s_a_low),
        .b_high      (s_b_high),
        .b_low       (s_b_low),
        .result_high (m_result_high),
        .result_low  (m_result_low),
        .overflow    (m_overflow),
        .bad_digit   (m_bad_digit)
    );

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_digit |-> m_result_high == '0 && m_result_low == '0 && !m_overflow)
        else $error("bad digit result not cleared");

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in flight");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !cmd.acc_en && !cmd.norm_en && !cmd.out_load)
        else $error("load overlaps a datapath step");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result load did not raise m_valid");
`endif

endmodule

FILE: src/bamu_ctrl.sv
// Controller for the decimal add / multiply unit.
// Sequences load, digit steps and result hand-off; drives bamu_dpath through bamu_cmd_t.
// Depends on bamu_pkg.
module bamu_ctrl #(
    parameter int DIGITS = bamu_pkg::DIGITS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  bamu_pkg::bamu_status_t status,
    output bamu_pkg::bamu_cmd_t    cmd
);
    import bamu_pkg::*;

    localparam int W     = (DIGITS < IO_DIGITS) ? DIGITS : IO_DIGITS;
    localparam int CNT_W = $clog2(W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W);

    bamu_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_RUN;
            end
            S_RUN: begin
                if (status.bad || cnt_reg == LAST_STEP) state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.load     = 1'b0;
        cmd.acc_en   = 1'b0;
        cmd.norm_en  = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_RUN: begin
                cmd.acc_en  = (cnt_reg != LAST_STEP);
                cmd.norm_en = (cnt_reg != '0);
            end
            S_FINISH: begin
                cmd.out_load = !out_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.load) begin
            cnt_next = '0;
        end else if (state_reg == S_RUN && cnt_reg != LAST_STEP) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/bamu_dpath.sv
// Datapath for the decimal add / multiply unit.
// Column accumulator window, one multiplier digit per step, serial carry normalizer
// and result registers. Depends on bamu_pkg.
module bamu_dpath #(
    parameter int DIGITS = bamu_pkg::DIGITS_DEFAULT
) (
    input  logic                          aclk,
    input  bamu_pkg::bamu_cmd_t           cmd,
    output bamu_pkg::bamu_status_t        status,
    input  logic                          operation,
    input  logic [bamu_pkg::HALF_W-1:0]   a_high,
    input  logic [bamu_pkg::HALF_W-1:0]   a_low,
    input  logic [bamu_pkg::HALF_W-1:0]   b_high,
    input  logic [bamu_pkg::HALF_W-1:0]   b_low,
    output logic [bamu_pkg::HALF_W-1:0]   result_high,
    output logic [bamu_pkg::HALF_W-1:0]   result_low,
    output logic                          overflow,
    output logic                          bad_digit
);
    import bamu_pkg::*;

    localparam int W = (DIGITS < IO_DIGITS) ? DIGITS : IO_DIGITS;

    logic [3:0]         a_reg    [W];
    logic [3:0]         a_next   [W];
    logic [3:0]         b_reg    [W];
    logic [3:0]         b_next   [W];
    logic [ACC_W-1:0]   win_reg  [W];
    logic [ACC_W-1:0]   win_next [W];
    logic [3:0]         res_reg  [W];
    logic [3:0]         res_next [W];
    logic [ACC_W-1:0]   emit_reg, emit_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic               op_reg, op_next;
    logic               bad_reg, bad_next;

    logic [HALF_W-1:0]  rh_reg, rh_next;
    logic [HALF_W-1:0]  rl_reg, rl_next;
    logic               ovf_reg, ovf_next;
    logic               badout_reg, badout_next;

    logic [IO_W-1:0]         in_a, in_b;
    logic                    in_bad;
    logic [ACC_W-1:0]        term [W];
    logic [ACC_W-1:0]        col  [W];
    logic [7:0]              prod;
    logic [ACC_W-1:0]        v;
    logic [RECIP_PROD_W-1:0] recip;
    logic [CARRY_W-1:0]      q;
    logic [ACC_W-1:0]        rem;
    logic                    high_nz;
    logic [IO_W-1:0]         res_full;

    // operand unpack and digit check
    always_comb begin
        in_a   = {a_high, a_low};
        in_b   = {b_high, b_low};
        in_bad = 1'b0;
        for (int i = 0; i < W; i++) begin
            if (in_a[4*i +: 4] > MAX_DIGIT || in_b[4*i +: 4] > MAX_DIGIT) in_bad = 1'b1;
        end
    end

    // column terms for this step
    always_comb begin
        prod = '0;
        for (int i = 0; i < W; i++) begin
            prod = 8'(a_reg[i]) * 8'(b_reg[0]);
            if (op_reg) begin
                term[i] = ACC_W'(prod);
            end else if (i == 0) begin
                term[i] = ACC_W'(a_reg[0]) + ACC_W'(b_reg[0]);
            end else begin
                term[i] = '0;
            end
            col[i] = win_reg[i] + term[i];
        end
    end

    // carry normalizer: v / 10 by reciprocal
    always_comb begin
        v     = emit_reg + ACC_W'(carry_reg);
        recip = RECIP_PROD_W'(v) * RECIP_PROD_W'(RECIP);
        q     = recip[RECIP_SHIFT +: CARRY_W];
        rem   = v - ((ACC_W'(q) << 3) + (ACC_W'(q) << 1));
    end

    always_comb begin
        high_nz  = 1'b0;
        res_full = '0;
        for (int i = 0; i < W; i++) begin
            if (win_reg[i] != '0) high_nz = 1'b1;
            res_full[4*i +: 4] = res_reg[i];
        end
    end

    always_comb begin
        op_next    = op_reg;
        bad_next   = bad_reg;
        emit_next  = emit_reg;
        carry_next = carry_reg;
        for (int i = 0; i < W; i++) begin
            a_next[i]   = a_reg[i];
            b_next[i]   = b_reg[i];
            win_next[i] = win_reg[i];
            res_next[i] = res_reg[i];
        end
        if (cmd.load) begin
            op_next    = operation;
            bad_next   = in_bad;
            emit_next  = '0;
            carry_next = '0;
            for (int i = 0; i < W; i++) begin
                a_next[i]   = in_a[4*i +: 4];
                b_next[i]   = in_b[4*i +: 4];
                win_next[i] = '0;
                res_next[i] = '0;
            end
        end else begin
            if (cmd.acc_en) begin
                emit_next = col[0];
                for (int i = 0; i < W; i++) begin
                    if (i < W - 1) begin
                        win_next[i] = col[i+1];
                        b_next[i]   = b_reg[i+1];
                        if (!op_reg) a_next[i] = a_reg[i+1];
                    end else begin
                        win_next[i] = '0;
                        b_next[i]   = '0;
                        if (!op_reg) a_next[i] = '0;
                    end
                end
            end
            if (cmd.norm_en) begin
                carry_next = q;
                for (int i = 0; i < W; i++) begin
                    res_next[i] = (i < W - 1) ? res_reg[i+1] : rem[3:0];
                end
            end
        end
    end

    always_comb begin
        rh_next     = rh_reg;
        rl_next     = rl_reg;
        ovf_next    = ovf_reg;
        badout_next = badout_reg;
        if (cmd.out_load) begin
            badout_next = bad_reg;
            if (bad_reg) begin
                rh_next  = '0;
                rl_next  = '0;
                ovf_next = 1'b0;
            end else begin
                rh_next  = res_full[IO_W-1:HALF_W];
                rl_next  = res_full[HALF_W-1:0];
                ovf_next = (carry_reg != '0) || high_nz;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        bad_reg    <= bad_next;
        emit_reg   <= emit_next;
        carry_reg  <= carry_next;
        rh_reg     <= rh_next;
        rl_reg     <= rl_next;
        ovf_reg    <= ovf_next;
        badout_reg <= badout_next;
        for (int i = 0; i < W; i++) begin
            a_reg[i]   <= a_next[i];
            b_reg[i]   <= b_next[i];
            win_reg[i] <= win_next[i];
            res_reg[i] <= res_next[i];
        end
    end

    assign status.bad  = bad_reg;
    assign result_high = rh_reg;
    assign result_low  = rl_reg;
    assign overflow    = ovf_reg;
    assign bad_digit   = badout_reg;

endmodule
